// ===== design/utf8_to_utf16_transcoder_assert.svh =====
// Assertion macros used by the transcoder checker.
`ifndef UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define U8U16_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u8u16 assertion failed");

// Next-cycle implication, clocked on clk, off during reset.
`define U8U16_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u8u16 assertion failed");

`endif

// ===== design/u8u16_pkg.sv =====
// Shared types, constants and the code point emitter of the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

  // output queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  localparam int POINT_W = 21;

  // surrogate tags in unit[15:10]
  localparam logic [5:0] SURR_HI_TAG = 6'b110110;
  localparam logic [5:0] SURR_LO_TAG = 6'b110111;

  localparam logic [15:0]        REPLACEMENT = 16'hFFFD;
  localparam logic [POINT_W-1:0] BMP_LIMIT   = 21'h00FFFF;
  localparam logic [POINT_W-1:0] MAX_POINT   = 21'h10FFFF;
  localparam logic [POINT_W-1:0] SUPP_BASE   = 21'h010000;

  typedef struct packed {
    logic [15:0] unit;
    logic        last;
  } unit_t;

  typedef struct packed {
    logic [1:0] n;
    unit_t      u0;
    unit_t      u1;
  } emit_t;

  // One unit up to 0xFFFF, a surrogate pair up to 0x10FFFF, else U+FFFD.
  function automatic emit_t emit_point(input logic [POINT_W-1:0] cp);
    emit_t                e;
    logic [POINT_W-1:0]   v;
    v = cp - SUPP_BASE;
    e = '0;
    if (cp <= BMP_LIMIT) begin
      e.n  = 2'd1;
      e.u0 = '{unit: cp[15:0], last: 1'b1};
    end else if (cp <= MAX_POINT) begin
      e.n  = 2'd2;
      e.u0 = '{unit: {SURR_HI_TAG, v[19:10]}, last: 1'b0};
      e.u1 = '{unit: {SURR_LO_TAG, v[9:0]}, last: 1'b1};
    end else begin
      e.n  = 2'd1;
      e.u0 = '{unit: REPLACEMENT, last: 1'b1};
    end
    return e;
  endfunction

endpackage

// ===== design/utf8_to_utf16_transcoder.sv =====
// UTF-8 to UTF-16 transcoder top level: byte register, decoder, output queue.
//
// Takes one UTF-8 byte per word on the in_ channel and delivers zero, one or
// two UTF-16 code units per byte on the out_ channel, out_last_of_run marking
// the final unit caused by a byte (low on the high surrogate of a pair). A
// byte is accepted every cycle in steady state: it is decoded against the
// pending code point while it sits in the input register, and its units land
// in a four-entry output queue, whose head is offered on out_ until taken.
// The decoder moves on only while the queue has room for a full surrogate
// pair; with out_ready held high that never stalls, since at most two units
// arrive per byte and one leaves per cycle.
// Stray continuation bytes and bytes 0xF8-0xFF are dropped silently, ASCII
// passes through without disturbing a pending sequence, a new lead restarts
// the sequence, and completed code points above 0x10FFFF come out as U+FFFD.
module utf8_to_utf16_transcoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_unit,
  output logic        out_last_of_run
);

  localparam int QDEPTH  = u8u16_pkg::QDEPTH;
  localparam int QPTR_W  = u8u16_pkg::QPTR_W;
  localparam int CNT_W   = u8u16_pkg::CNT_W;
  localparam int POINT_W = u8u16_pkg::POINT_W;

  // input register
  logic       hold_vld_r;
  logic [7:0] hold_byte_r;

  // decoder state
  logic [POINT_W-1:0] pend_r, pend_nxt;
  logic [1:0]         left_r, left_nxt;

  // output queue
  u8u16_pkg::unit_t q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;

  logic                 adv;
  logic                 pop;
  u8u16_pkg::emit_t     em;
  logic [POINT_W-1:0]   cp;

  // decode step may run only with room for a pair
  assign adv      = hold_vld_r && (cnt_r <= CNT_W'(QDEPTH - 2));
  assign in_ready = !hold_vld_r || adv;

  assign out_valid       = (cnt_r != '0);
  assign out_unit        = q_r[rd_ptr_r].unit;
  assign out_last_of_run = q_r[rd_ptr_r].last;
  assign pop             = out_valid && out_ready;

  // decoder
  always_comb begin
    pend_nxt = pend_r;
    left_nxt = left_r;
    em       = '0;
    cp       = {pend_r[POINT_W-7:0], hold_byte_r[5:0]};
    if (hold_byte_r[7:6] == 2'b10) begin
      // continuation: dropped when nothing is pending
      if (left_r != 2'd0) begin
        left_nxt = left_r - 2'd1;
        if (left_r == 2'd1) begin
          em       = u8u16_pkg::emit_point(cp);
          pend_nxt = '0;
        end else begin
          pend_nxt = cp;
        end
      end
    end else if (!hold_byte_r[7]) begin
      // ASCII, pending sequence kept
      em.n  = 2'd1;
      em.u0 = '{unit: {8'h00, hold_byte_r}, last: 1'b1};
    end else if (hold_byte_r[7:5] == 3'b110) begin
      pend_nxt = {{(POINT_W-5){1'b0}}, hold_byte_r[4:0]};
      left_nxt = 2'd1;
    end else if (hold_byte_r[7:4] == 4'b1110) begin
      pend_nxt = {{(POINT_W-4){1'b0}}, hold_byte_r[3:0]};
      left_nxt = 2'd2;
    end else if (hold_byte_r[7:3] == 5'b11110) begin
      pend_nxt = {{(POINT_W-3){1'b0}}, hold_byte_r[2:0]};
      left_nxt = 2'd3;
    end
    // 0xF8-0xFF fall through: dropped
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      pend_r     <= '0;
      left_r     <= '0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      cnt_r      <= '0;
    end else begin
      if (in_valid && in_ready) begin
        hold_vld_r <= 1'b1;
      end else if (adv) begin
        hold_vld_r <= 1'b0;
      end
      if (adv) begin
        pend_r   <= pend_nxt;
        left_r   <= left_nxt;
        wr_ptr_r <= wr_ptr_r + QPTR_W'(em.n);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + (adv ? CNT_W'(em.n) : CNT_W'(0)) - CNT_W'(pop);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte_r <= in_byte;
    end
    if (adv && (em.n != 2'd0)) begin
      q_r[wr_ptr_r] <= em.u0;
    end
    if (adv && (em.n == 2'd2)) begin
      q_r[wr_ptr_r + QPTR_W'(1)] <= em.u1;
    end
  end

endmodule

// ===== design/u8u16_checker.sv =====
// Port-level checker for the UTF-8 to UTF-16 transcoder, bound to the top level.
`include "utf8_to_utf16_transcoder_assert.svh"

module u8u16_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_unit,
  input logic        out_last_of_run
);

  // stalled result holds
  `U8U16_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_unit) && $stable(out_last_of_run))

  // only a high surrogate is ever marked not last
  `U8U16_ASSERT_IMP(a_not_last_is_high, out_valid && !out_last_of_run, out_unit[15:10] == u8u16_pkg::SURR_HI_TAG)

  // low surrogate is queued right behind its high half
  `U8U16_ASSERT_NXT(a_low_follows, out_valid && out_ready && !out_last_of_run, out_valid && out_last_of_run && (out_unit[15:10] == u8u16_pkg::SURR_LO_TAG))

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_u8u16_checker (.*);
